// ===== src/risc_execute_unit_assert.svh =====
// Assertion macros used by the execute unit controller.
`ifndef RISC_EXECUTE_UNIT_ASSERT_SVH
`define RISC_EXECUTE_UNIT_ASSERT_SVH

// Property that must hold at every clock edge outside reset.
`define REU_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication checked at the clock edge after the trigger.
`define REU_ASSERT_NEXT(label, trig, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) \
        else $error(msg);

`endif

// ===== src/reu_pkg.sv =====
//------------------------------------------------------------------------------
// reu_pkg
// Shared types and constants of the execute unit.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

package reu_pkg;

    localparam int NUM_REGS  = 32;
    localparam int MEM_WORDS = 1024;
    localparam int RIDX_W    = $clog2(NUM_REGS);
    localparam int MADDR_W   = $clog2(MEM_WORDS);

    localparam logic [1:0] ACT_EXEC = 2'd0;
    localparam logic [1:0] ACT_PREG = 2'd1;
    localparam logic [1:0] ACT_PMEM = 2'd2;

    localparam logic [4:0] OP_NOP   = 5'd0;
    localparam logic [4:0] OP_MOV   = 5'd1;
    localparam logic [4:0] OP_ADD   = 5'd2;
    localparam logic [4:0] OP_SUB   = 5'd3;
    localparam logic [4:0] OP_MUL   = 5'd4;
    localparam logic [4:0] OP_DIV   = 5'd5;
    localparam logic [4:0] OP_CMP   = 5'd6;
    localparam logic [4:0] OP_LD    = 5'd7;
    localparam logic [4:0] OP_ST    = 5'd8;
    localparam logic [4:0] OP_LDR   = 5'd9;
    localparam logic [4:0] OP_STR   = 5'd10;
    localparam logic [4:0] OP_LDC   = 5'd11;
    localparam logic [4:0] OP_B     = 5'd12;
    localparam logic [4:0] OP_BZ    = 5'd13;
    localparam logic [4:0] OP_BNZ   = 5'd14;
    localparam logic [4:0] OP_BLTZ  = 5'd15;
    localparam logic [4:0] OP_BLEZ  = 5'd16;
    localparam logic [4:0] OP_BGTZ  = 5'd17;
    localparam logic [4:0] OP_BGEZ  = 5'd18;
    localparam logic [4:0] OP_PRNT  = 5'd19;
    localparam logic [4:0] OP_HLT   = 5'd20;

    localparam logic [1:0] PRED_TAKEN     = 2'd1;
    localparam logic [1:0] PRED_NOT_TAKEN = 2'd2;

    // Controller to datapath commands.
    typedef struct packed {
        logic capture;    // latch input transaction, start register reads
        logic clr_step;   // write one cleared memory row
        logic execute;    // compute, write back, start memory access
        logic div_start;
        logic finish;     // load output register
        logic out_take;   // output transaction completed
    } reu_cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic clr_done;
        logic is_div;
        logic is_load;
        logic div_done;
    } reu_status_t;

endpackage

// ===== src/reu_divider.sv =====
//------------------------------------------------------------------------------
// reu_divider
// Radix-2 restoring signed divider, one quotient bit per cycle.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module reu_divider
    import reu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [31:0] quotient
);

    logic [31:0] rem_reg, quo_reg, div_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg, neg_reg, zero_reg, done_reg;
    logic [32:0] trial;
    logic [31:0] rem_sh;
    logic [31:0] mag_a, mag_b;

    assign mag_a  = dividend[31] ? (32'd0 - dividend) : dividend;
    assign mag_b  = divisor[31] ? (32'd0 - divisor) : divisor;
    assign rem_sh = {rem_reg[30:0], quo_reg[31]};
    assign trial  = {1'b0, rem_sh} - {1'b0, div_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'd32;
                rem_reg  <= '0;
                quo_reg  <= mag_a;
                div_reg  <= mag_b;
                neg_reg  <= dividend[31] ^ divisor[31];
                zero_reg <= (divisor == 32'd0);
            end
            else if (busy_reg)
            begin
                if (trial[32])
                begin
                    rem_reg <= rem_sh;
                    quo_reg <= {quo_reg[30:0], 1'b0};
                end
                else
                begin
                    rem_reg <= trial[31:0];
                    quo_reg <= {quo_reg[30:0], 1'b1};
                end
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = zero_reg ? 32'hFFFF_FFFF : (neg_reg ? (32'd0 - quo_reg) : quo_reg);

endmodule

// ===== src/reu_datapath.sv =====
//------------------------------------------------------------------------------
// reu_datapath
// Register file, data memory, ALU, branch resolution and output register.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module reu_datapath
    import reu_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  reu_cmd_t           cmd,
    output reu_status_t        status,
    input  logic [1:0]         action,
    input  logic [4:0]         opcode,
    input  logic [4:0]         dest_reg,
    input  logic [4:0]         src_a_reg,
    input  logic [4:0]         src_b_reg,
    input  logic signed [15:0] immediate,
    input  logic [31:0]        pc_value,
    input  logic [1:0]         prediction,
    input  logic [31:0]        preload_value,
    output logic [31:0]        resolved_pc,
    output logic               is_branch,
    output logic               branch_taken,
    output logic               mispredicted,
    output logic               halt_seen,
    output logic               print_valid,
    output logic [31:0]        print_word,
    output logic               unknown_op
);

    logic [31:0] rf_mem [NUM_REGS];
    logic [31:0] dmem [MEM_WORDS];

    logic [1:0]  act_reg;
    logic [4:0]  op_reg;
    logic [RIDX_W-1:0] d_reg;
    logic [31:0] imm_reg, pc_reg, pval_reg;
    logic [1:0]  pred_reg;
    logic [31:0] rd_reg, ra_reg, rb_reg;
    logic [31:0] mul_reg;
    logic [31:0] mem_rdata_reg;
    logic        load_pend_reg;

    logic [MADDR_W:0] clr_cnt_reg;

    logic        wr_rf;
    logic [31:0] wr_val;
    logic        wr_mem;
    logic [MADDR_W-1:0] mem_addr;
    logic [31:0] mem_wdata;
    logic        taken, jump, isbr, unk;
    logic        is_div, is_load;

    logic        div_done;
    logic [31:0] div_q;

    reu_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (ra_reg),
        .divisor  (rb_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    assign is_div  = (act_reg == ACT_EXEC) && (op_reg == OP_DIV);
    assign is_load = (act_reg == ACT_EXEC) && ((op_reg == OP_LD) || (op_reg == OP_LDR));

    // Capture the transaction and read the register file.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            act_reg  <= action;
            op_reg   <= opcode;
            d_reg    <= dest_reg[RIDX_W-1:0];
            imm_reg  <= {{16{immediate[15]}}, immediate};
            pc_reg   <= pc_value;
            pred_reg <= prediction;
            pval_reg <= preload_value;
            rd_reg   <= rf_mem[dest_reg[RIDX_W-1:0]];
            ra_reg   <= rf_mem[src_a_reg[RIDX_W-1:0]];
            rb_reg   <= rf_mem[src_b_reg[RIDX_W-1:0]];
        end
    end

    // Product registered from the captured operands; used at execute.
    always_ff @(posedge clk)
    begin
        mul_reg <= ra_reg * rb_reg;
    end

    always_comb
    begin
        wr_rf     = 1'b0;
        wr_val    = '0;
        wr_mem    = 1'b0;
        mem_addr  = imm_reg[MADDR_W-1:0];
        mem_wdata = rd_reg;
        isbr      = 1'b0;
        taken     = 1'b0;
        jump      = 1'b0;
        unk       = 1'b0;
        case (act_reg)
            ACT_PREG:
            begin
                wr_rf  = 1'b1;
                wr_val = pval_reg;
            end
            ACT_PMEM:
            begin
                wr_mem    = 1'b1;
                mem_wdata = pval_reg;
            end
            ACT_EXEC:
            begin
                case (op_reg)
                    OP_MOV: begin wr_rf = 1'b1; wr_val = ra_reg; end
                    OP_ADD: begin wr_rf = 1'b1; wr_val = ra_reg + rb_reg; end
                    OP_SUB: begin wr_rf = 1'b1; wr_val = ra_reg - rb_reg; end
                    OP_MUL: begin wr_rf = 1'b1; wr_val = mul_reg; end
                    OP_DIV: begin wr_rf = 1'b1; wr_val = div_q; end
                    OP_CMP:
                    begin
                        wr_rf  = 1'b1;
                        wr_val = (ra_reg < rb_reg) ? 32'hFFFF_FFFF :
                                 ((ra_reg > rb_reg) ? 32'd1 : 32'd0);
                    end
                    OP_LD: mem_addr = imm_reg[MADDR_W-1:0];
                    OP_ST: wr_mem = 1'b1;
                    OP_LDR: mem_addr = ra_reg[MADDR_W-1:0];
                    OP_STR:
                    begin
                        wr_mem    = 1'b1;
                        mem_addr  = rd_reg[MADDR_W-1:0];
                        mem_wdata = ra_reg;
                    end
                    OP_LDC: begin wr_rf = 1'b1; wr_val = imm_reg; end
                    OP_B: jump = 1'b1;
                    OP_BZ: begin isbr = 1'b1; taken = (rd_reg == 32'd0); end
                    OP_BNZ: begin isbr = 1'b1; taken = (rd_reg != 32'd0); end
                    OP_BLTZ: begin isbr = 1'b1; taken = rd_reg[31]; end
                    OP_BLEZ: begin isbr = 1'b1; taken = rd_reg[31] || (rd_reg == 32'd0); end
                    OP_BGTZ: begin isbr = 1'b1; taken = !rd_reg[31] && (rd_reg != 32'd0); end
                    OP_BGEZ: begin isbr = 1'b1; taken = !rd_reg[31]; end
                    OP_NOP, OP_PRNT, OP_HLT: ;
                    default: unk = 1'b1;
                endcase
                jump = jump || taken;
            end
            default: ;
        endcase
    end

    // Register file write: cleared during the reset pass, normal ops at
    // execute, loads in the cycle after execute.
    always_ff @(posedge clk)
    begin
        if (cmd.clr_step && !clr_cnt_reg[MADDR_W])
            rf_mem[clr_cnt_reg[RIDX_W-1:0]] <= '0;
        else if (load_pend_reg)
            rf_mem[d_reg] <= mem_rdata_reg;
        else if (cmd.execute && wr_rf)
            rf_mem[d_reg] <= wr_val;
    end

    // Clearing pass through data memory after reset, one word a cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg   <= '0;
            load_pend_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr_step && !clr_cnt_reg[MADDR_W])
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            load_pend_reg <= cmd.execute && is_load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clr_step && !clr_cnt_reg[MADDR_W])
            dmem[clr_cnt_reg[MADDR_W-1:0]] <= '0;
        else if (cmd.execute && wr_mem)
            dmem[mem_addr] <= mem_wdata;
        mem_rdata_reg <= dmem[mem_addr];
    end

    // Output register.
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            resolved_pc  <= jump ? (pc_reg + imm_reg) : pc_reg;
            is_branch    <= isbr;
            branch_taken <= taken;
            mispredicted <= isbr && (((pred_reg == PRED_TAKEN) && !taken) ||
                                     ((pred_reg == PRED_NOT_TAKEN) && taken));
            halt_seen    <= (act_reg == ACT_EXEC) && (op_reg == OP_HLT);
            print_valid  <= (act_reg == ACT_EXEC) && (op_reg == OP_PRNT);
            print_word   <= ((act_reg == ACT_EXEC) && (op_reg == OP_PRNT)) ? rd_reg : 32'd0;
            unknown_op   <= unk;
        end
    end

    assign status.clr_done = clr_cnt_reg[MADDR_W];
    assign status.is_div   = is_div;
    assign status.is_load  = is_load;
    assign status.div_done = div_done;

endmodule

// ===== src/reu_ctrl.sv =====
//------------------------------------------------------------------------------
// reu_ctrl
// Sequencer of the execute unit: clear, capture, divide wait, execute, deliver.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "risc_execute_unit_assert.svh"

module reu_ctrl
    import reu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    output logic        out_valid,
    input  logic        out_ready,
    input  reu_status_t status,
    output reu_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_EXEC,
        ST_LOAD,
        ST_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (status.clr_done)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_MUL;
                end
            end
            ST_MUL:
            begin
                if (status.is_div)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end
                else
                    state_next = ST_EXEC;
            end
            ST_DIV:
            begin
                if (status.div_done)
                    state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                cmd.execute = 1'b1;
                cmd.finish  = 1'b1;
                state_next  = status.is_load ? ST_LOAD : ST_OUT;
            end
            ST_LOAD:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_ready)
                begin
                    cmd.out_take = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= (state_next == ST_OUT);
        end
    end

    assign out_valid = out_valid_reg;

    `REU_ASSERT(a_one_side, !(in_ready && out_valid), "input open while result pending")
    `REU_ASSERT_NEXT(a_cap_busy, cmd.capture, !in_ready, "capture did not close input")
    `REU_ASSERT_NEXT(a_take_idle, cmd.out_take, in_ready, "no return to idle after output")
    `REU_ASSERT(a_clr_quiet, !(state_reg == ST_CLEAR && (in_ready || out_valid)),
        "handshake during memory clear")

endmodule

// ===== src/risc_execute_unit.sv =====
//------------------------------------------------------------------------------
// risc_execute_unit
// Single-issue execute unit with register file and data memory.
//------------------------------------------------------------------------------
// Usage: present one transaction on the input channel (in_valid/in_ready);
// action selects execute, register preload or memory preload. Exactly one
// result transaction follows on the output channel (out_valid/out_ready).
// One transaction is in flight at a time; in_ready is high only when idle.
// After acceptance the operands are captured and the multiply product is
// registered; a divide then waits on the radix-2 divider, one quotient bit
// per cycle. The execute step writes back and loads the output register; a
// load also passes through the load state for the registered memory read.
// After the output transaction the unit returns to idle for the next accept.
// Reset: a clearing pass over all MEM_WORDS (1024) words zeroes the data
// memory and the register file; in_ready stays low during the pass.
// A stalled receiver holds the result in the output register; no new input
// is accepted until it is taken.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module risc_execute_unit
    import reu_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         action,
    input  logic [4:0]         opcode,
    input  logic [4:0]         dest_reg,
    input  logic [4:0]         src_a_reg,
    input  logic [4:0]         src_b_reg,
    input  logic signed [15:0] immediate,
    input  logic [31:0]        pc_value,
    input  logic [1:0]         prediction,
    input  logic [31:0]        preload_value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [31:0]        resolved_pc,
    output logic               is_branch,
    output logic               branch_taken,
    output logic               mispredicted,
    output logic               halt_seen,
    output logic               print_valid,
    output logic [31:0]        print_word,
    output logic               unknown_op
);

    reu_cmd_t    cmd;
    reu_status_t status;

    reu_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    reu_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .action        (action),
        .opcode        (opcode),
        .dest_reg      (dest_reg),
        .src_a_reg     (src_a_reg),
        .src_b_reg     (src_b_reg),
        .immediate     (immediate),
        .pc_value      (pc_value),
        .prediction    (prediction),
        .preload_value (preload_value),
        .resolved_pc   (resolved_pc),
        .is_branch     (is_branch),
        .branch_taken  (branch_taken),
        .mispredicted  (mispredicted),
        .halt_seen     (halt_seen),
        .print_valid   (print_valid),
        .print_word    (print_word),
        .unknown_op    (unknown_op)
    );

endmodule

// ===== sim/tb_top.sv =====
//------------------------------------------------------------------------------
// tb_top
// Self-checking bench for the execute unit.
//------------------------------------------------------------------------------
// A directed set of preloads and instructions covers operand extremes, every
// opcode but NOP, divide by zero and overflow, compare outcomes, address wrap,
// all branch predictions and the unused action. A long random run follows.
// Each accepted transaction runs through a local model of the register file
// and data memory. Every result is checked field by field. Both channels
// insert random gaps.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import reu_pkg::*;

    localparam logic [1:0] ACT_NONE = 2'd3;

    typedef struct {
        logic [1:0]  act;
        logic [4:0]  op;
        logic [4:0]  rd;
        logic [4:0]  ra;
        logic [4:0]  rb;
        logic [15:0] imm;
        logic [31:0] pc;
        logic [1:0]  pred;
        logic [31:0] pval;
    } instr_t;

    typedef struct {
        logic [31:0] rpc;
        logic        isbr;
        logic        taken;
        logic        mis;
        logic        halt;
        logic        prnt;
        logic [31:0] pword;
        logic        unk;
    } outcome_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [1:0] action = '0;
    logic [4:0] opcode = '0;
    logic [4:0] dest_reg = '0;
    logic [4:0] src_a_reg = '0;
    logic [4:0] src_b_reg = '0;
    logic signed [15:0] immediate = '0;
    logic [31:0] pc_value = '0;
    logic [1:0] prediction = '0;
    logic [31:0] preload_value = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [31:0] resolved_pc;
    logic is_branch;
    logic branch_taken;
    logic mispredicted;
    logic halt_seen;
    logic print_valid;
    logic [31:0] print_word;
    logic unknown_op;

    instr_t   instr_queue[$];
    outcome_t pending_results[$];
    logic [31:0] shadow_regs[NUM_REGS];
    logic [31:0] shadow_mem[MEM_WORDS];
    int errors = 0;
    int results_seen = 0;
    int branches_seen = 0;
    int mispredicts_seen = 0;
    int in_gap = 0;
    int out_stall = 0;
    bit calm = 1'b0;

    risc_execute_unit uut (.*);

    always #2 clk = ~clk;

    function automatic logic [31:0] signed_quotient(logic [31:0] a, logic [31:0] b);
        if (b == 32'd0)
            return 32'hFFFF_FFFF;
        if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF)
            return 32'h8000_0000;
        return $signed(a) / $signed(b);
    endfunction

    // Apply one transaction to the shadow state and return its outcome.
    function automatic outcome_t execute_model(instr_t t);
        outcome_t o;
        logic [31:0] rdv, rav, rbv, sx;
        logic jump;
        o = '{rpc: t.pc, default: '0};
        sx = {{16{t.imm[15]}}, t.imm};
        rdv = shadow_regs[t.rd];
        rav = shadow_regs[t.ra];
        rbv = shadow_regs[t.rb];
        jump = 1'b0;
        if (t.act == ACT_PREG)
            shadow_regs[t.rd] = t.pval;
        else if (t.act == ACT_PMEM)
            shadow_mem[sx[MADDR_W-1:0]] = t.pval;
        else if (t.act == ACT_EXEC) begin
            case (t.op)
                OP_NOP: ;
                OP_MOV: shadow_regs[t.rd] = rav;
                OP_ADD: shadow_regs[t.rd] = rav + rbv;
                OP_SUB: shadow_regs[t.rd] = rav - rbv;
                OP_MUL: shadow_regs[t.rd] = rav * rbv;
                OP_DIV: shadow_regs[t.rd] = signed_quotient(rav, rbv);
                OP_CMP: shadow_regs[t.rd] = (rav < rbv) ? 32'hFFFF_FFFF :
                                            (rav > rbv) ? 32'd1 : 32'd0;
                OP_LD:  shadow_regs[t.rd] = shadow_mem[sx[MADDR_W-1:0]];
                OP_ST:  shadow_mem[sx[MADDR_W-1:0]] = rdv;
                OP_LDR: shadow_regs[t.rd] = shadow_mem[rav[MADDR_W-1:0]];
                OP_STR: shadow_mem[rdv[MADDR_W-1:0]] = rav;
                OP_LDC: shadow_regs[t.rd] = sx;
                OP_B:   jump = 1'b1;
                OP_BZ:    begin o.isbr = 1'b1; o.taken = (rdv == 0); end
                OP_BNZ:   begin o.isbr = 1'b1; o.taken = (rdv != 0); end
                OP_BLTZ:  begin o.isbr = 1'b1; o.taken = rdv[31]; end
                OP_BLEZ:  begin o.isbr = 1'b1; o.taken = rdv[31] || rdv == 0; end
                OP_BGTZ:  begin o.isbr = 1'b1; o.taken = !rdv[31] && rdv != 0; end
                OP_BGEZ:  begin o.isbr = 1'b1; o.taken = !rdv[31]; end
                OP_PRNT: begin o.prnt = 1'b1; o.pword = rdv; end
                OP_HLT:  o.halt = 1'b1;
                default: o.unk = 1'b1;
            endcase
            if (o.isbr) begin
                jump = o.taken;
                o.mis = (t.pred == PRED_TAKEN && !o.taken) ||
                        (t.pred == PRED_NOT_TAKEN && o.taken);
            end
            if (jump)
                o.rpc = t.pc + sx;
        end
        return o;
    endfunction

    task automatic push(logic [1:0] act, logic [4:0] op, logic [4:0] rd, logic [4:0] ra,
                        logic [4:0] rb, logic [15:0] imm, logic [1:0] pred, logic [31:0] pval);
        instr_t t;
        t = '{act, op, rd, ra, rb, imm, $urandom, pred, pval};
        instr_queue.push_back(t);
    endtask

    function automatic logic [31:0] edge_word();
        case ($urandom_range(0, 6))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'h7FFF_FFFF;
            4: return $urandom_range(0, 2047);
            default: return $urandom;
        endcase
    endfunction

    // Input side: hold the transaction until taken, then idle for the drawn gap.
    always @(posedge clk or negedge rst_n) begin
        bit nv;
        instr_t t;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end
        else begin
            nv = in_valid;
            if (in_valid && in_ready) begin
                t = '{action, opcode, dest_reg, src_a_reg, src_b_reg, immediate,
                      pc_value, prediction, preload_value};
                pending_results.push_back(execute_model(t));
                nv = 1'b0;
            end
            if (!nv) begin
                if (in_gap > 0)
                    in_gap--;
                else if (instr_queue.size() > 0) begin
                    t = instr_queue.pop_front();
                    action <= t.act;
                    opcode <= t.op;
                    dest_reg <= t.rd;
                    src_a_reg <= t.ra;
                    src_b_reg <= t.rb;
                    immediate <= t.imm;
                    pc_value <= t.pc;
                    prediction <= t.pred;
                    preload_value <= t.pval;
                    nv = 1'b1;
                    if ($urandom_range(0, 99) == 0)
                        calm = !calm;
                    in_gap = calm ? 0 : $urandom_range(0, 13);
                end
            end
            in_valid <= nv;
        end
    end

    // Output side: check each result, then stall for the drawn count.
    always @(posedge clk or negedge rst_n) begin
        outcome_t e;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end
        else begin
            if (out_valid && out_ready) begin
                results_seen++;
                if (pending_results.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result, resolved_pc %h", $time, resolved_pc);
                end
                else begin
                    e = pending_results.pop_front();
                    branches_seen += e.isbr;
                    mispredicts_seen += e.mis;
                    if (resolved_pc !== e.rpc) begin
                        errors++;
                        $display("%0t: resolved_pc exp %h got %h", $time, e.rpc, resolved_pc);
                    end
                    if (is_branch !== e.isbr) begin
                        errors++;
                        $display("%0t: is_branch exp %b got %b", $time, e.isbr, is_branch);
                    end
                    if (branch_taken !== e.taken) begin
                        errors++;
                        $display("%0t: branch_taken exp %b got %b", $time, e.taken,
                                 branch_taken);
                    end
                    if (mispredicted !== e.mis) begin
                        errors++;
                        $display("%0t: mispredicted exp %b got %b", $time, e.mis,
                                 mispredicted);
                    end
                    if (halt_seen !== e.halt) begin
                        errors++;
                        $display("%0t: halt_seen exp %b got %b", $time, e.halt, halt_seen);
                    end
                    if (print_valid !== e.prnt) begin
                        errors++;
                        $display("%0t: print_valid exp %b got %b", $time, e.prnt, print_valid);
                    end
                    if (print_word !== e.pword) begin
                        errors++;
                        $display("%0t: print_word exp %h got %h", $time, e.pword, print_word);
                    end
                    if (unknown_op !== e.unk) begin
                        errors++;
                        $display("%0t: unknown_op exp %b got %b", $time, e.unk, unknown_op);
                    end
                end
                out_stall = calm ? 0 : $urandom_range(0, 13);
            end
            if (out_stall > 0) begin
                out_stall--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    initial begin
        int r;
        logic [4:0] op;
        foreach (shadow_regs[i]) shadow_regs[i] = '0;
        foreach (shadow_mem[i]) shadow_mem[i] = '0;

        // Directed: operand extremes and every opcode except NOP.
        push(ACT_PREG, OP_NOP, 5'd1, 5'd0, 5'd0, 16'h0, 2'd0, 32'h8000_0000);
        push(ACT_PREG, OP_NOP, 5'd2, 5'd0, 5'd0, 16'h0, 2'd0, 32'hFFFF_FFFF);
        push(ACT_PREG, OP_NOP, 5'd31, 5'd0, 5'd0, 16'h0, 2'd0, 32'h7FFF_FFFF);
        push(ACT_PMEM, OP_NOP, 5'd0, 5'd0, 5'd0, 16'hFFFF, 2'd0, 32'hA5A5_5A5A);
        push(ACT_PMEM, OP_NOP, 5'd0, 5'd0, 5'd0, 16'h7FFF, 2'd0, 32'h1234_5678);
        push(ACT_EXEC, OP_DIV, 5'd3, 5'd1, 5'd2, 16'h0, 2'd0, 32'h0);   // overflow
        push(ACT_EXEC, OP_DIV, 5'd4, 5'd31, 5'd0, 16'h0, 2'd0, 32'h0);  // by zero
        push(ACT_EXEC, OP_DIV, 5'd5, 5'd31, 5'd2, 16'h0, 2'd0, 32'h0);
        for (int k = 1; k <= 6; k++)
            push(ACT_EXEC, 5'(k), 5'(k + 5), 5'd1, 5'd31, 16'h0, 2'd0, 32'h0);
        push(ACT_EXEC, OP_CMP, 5'd12, 5'd2, 5'd2, 16'h0, 2'd0, 32'h0);
        push(ACT_EXEC, OP_CMP, 5'd13, 5'd2, 5'd1, 16'h0, 2'd0, 32'h0);
        push(ACT_EXEC, OP_LD, 5'd14, 5'd0, 5'd0, 16'h03FF, 2'd0, 32'h0); // reads the word that -1 wraps to
        push(ACT_EXEC, OP_ST, 5'd31, 5'd0, 5'd0, 16'h8000, 2'd0, 32'h0);
        push(ACT_EXEC, OP_STR, 5'd2, 5'd1, 5'd0, 16'h0, 2'd0, 32'h0);
        push(ACT_EXEC, OP_LDR, 5'd15, 5'd2, 5'd0, 16'h0, 2'd0, 32'h0);
        push(ACT_EXEC, OP_LDC, 5'd16, 5'd0, 5'd0, 16'h8000, 2'd0, 32'h0);
        push(ACT_EXEC, OP_B, 5'd0, 5'd0, 5'd0, 16'hFFF0, 2'd1, 32'h0);
        for (int k = OP_BZ; k <= OP_BGEZ; k++)
            push(ACT_EXEC, 5'(k), 5'(k % 3), 5'd0, 5'd0, 16'h0010, 2'(k % 4), 32'h0);
        push(ACT_EXEC, OP_PRNT, 5'd2, 5'd0, 5'd0, 16'h0, 2'd0, 32'h0);
        push(ACT_EXEC, OP_HLT, 5'd0, 5'd0, 5'd0, 16'h0, 2'd0, 32'h0);
        push(ACT_EXEC, 5'd31, 5'd9, 5'd9, 5'd9, 16'h0, 2'd0, 32'h0);
        push(ACT_NONE, OP_ADD, 5'd9, 5'd1, 5'd2, 16'h1, 2'd3, 32'hFFFF_FFFF);

        // Random: preloads and defined instructions over a register file of edge values.
        for (int n = 0; n < 1250; n++) begin
            r = $urandom_range(0, 99);
            op = (r < 8) ? 5'($urandom_range(21, 31)) : 5'($urandom_range(0, 20));
            if (r < 22)
                push(ACT_PREG, 5'($urandom), 5'($urandom), 5'($urandom), 5'($urandom),
                     16'($urandom), 2'($urandom), edge_word());
            else if (r < 28)
                push(ACT_PMEM, 5'($urandom), 5'($urandom), 5'($urandom), 5'($urandom),
                     16'($urandom), 2'($urandom), edge_word());
            else if (r < 31)
                push(ACT_NONE, 5'($urandom), 5'($urandom), 5'($urandom), 5'($urandom),
                     16'($urandom), 2'($urandom), $urandom);
            else
                push(ACT_EXEC, op, 5'($urandom), 5'($urandom), 5'($urandom),
                     16'($urandom), 2'($urandom), $urandom);
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        wait (instr_queue.size() == 0 && !in_valid && pending_results.size() == 0);
        repeat (60) @(posedge clk);
        $display("Ran %0d results: %0d conditional branches, %0d mispredicted.",
                 results_seen, branches_seen, mispredicts_seen);
        if (errors == 0 && pending_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial begin
        #3ms;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
